[sv/b64d_pkg.sv]
// Shared types and constants for the base64 text decoder.
// Used by b64d_char_class, b64d_core and the base64_text_decoder top level.
`default_nettype none

package b64d_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam int unsigned CAP_BITS = 16;
    localparam int unsigned GROUP_BITS = 18;

    // Status codes reported with the end-of-string result.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_OVERFLOW    = 3'd1;
    localparam logic [2:0] ST_BAD_PAD     = 3'd2;
    localparam logic [2:0] ST_PAD_MISSING = 3'd3;
    localparam logic [2:0] ST_LEFTOVER    = 3'd4;
    localparam logic [2:0] ST_TRUNCATED   = 3'd5;
    localparam logic [2:0] ST_INVALID     = 3'd6;

    typedef enum logic [2:0] {
        PAD_NONE = 3'b001,
        PAD_ONE  = 3'b010,
        PAD_DONE = 3'b100
    } t_pad_stage;

    typedef struct packed {
        logic       is_end;
        logic       is_space;
        logic       is_pad;
        logic       is_alpha;
        logic [5:0] sextet;
    } t_char_info;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        done_res;
        logic [2:0]  status;
        logic [15:0] byte_count;
    } t_result;

endpackage

`default_nettype wire

[sv/b64d_char_class.sv]
// Character classifier: end marker, whitespace, pad and alphabet lookup.
// Depends on b64d_pkg for the classification struct.
`default_nettype none

module b64d_char_class (
    input  wire logic [7:0]          i_ch,
    output b64d_pkg::t_char_info     o_info
);
    import b64d_pkg::*;

    always_comb begin
        o_info          = '0;
        o_info.is_end   = (i_ch == 8'h00);
        o_info.is_space = (i_ch == 8'h20) || (i_ch >= 8'h09 && i_ch <= 8'h0D);
        o_info.is_pad   = (i_ch == PAD_CHAR);
        o_info.is_alpha = 1'b1;
        if (i_ch >= 8'h41 && i_ch <= 8'h5A) begin
            o_info.sextet = 6'(i_ch - 8'h41);
        end else if (i_ch >= 8'h61 && i_ch <= 8'h7A) begin
            o_info.sextet = 6'(i_ch - 8'h61 + 8'd26);
        end else if (i_ch >= 8'h30 && i_ch <= 8'h39) begin
            o_info.sextet = 6'(i_ch - 8'h30 + 8'd52);
        end else if (i_ch == 8'h2B) begin
            o_info.sextet = 6'd62;
        end else if (i_ch == 8'h2F) begin
            o_info.sextet = 6'd63;
        end else begin
            o_info.is_alpha = 1'b0;
        end
    end

endmodule

`default_nettype wire

[sv/b64d_core.sv]
// Decoder state and per-character update: group phase, partial byte, padding,
// counters, sticky error and the capacity register. Depends on b64d_pkg.
`default_nettype none

module b64d_core #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [15:0]             i_cfg_wr_data,
    input  wire logic                    i_fire,
    input  wire b64d_pkg::t_char_info    i_info,
    output logic                         o_emit,
    output b64d_pkg::t_result            o_result
);
    import b64d_pkg::*;

    logic [CAP_BITS-1:0]   r_capacity;
    logic [1:0]            r_phase,       n_phase;
    logic [7:0]            r_partial,     n_partial;
    t_pad_stage            r_pad,         n_pad;
    logic [COUNT_BITS-1:0] r_count,       n_count;
    logic [GROUP_BITS-1:0] r_group_bytes, n_group_bytes;
    logic [2:0]            r_error,       n_error;
    logic [GROUP_BITS-1:0] group_sum;
    logic [31:0]           count_wide;
    logic [5:0]            v;

    assign group_sum  = r_group_bytes + GROUP_BITS'(3);
    assign count_wide = 32'(r_count);
    assign v          = i_info.sextet;

    always_comb begin
        n_phase       = r_phase;
        n_partial     = r_partial;
        n_pad         = r_pad;
        n_count       = r_count;
        n_group_bytes = r_group_bytes;
        n_error       = r_error;
        o_emit        = 1'b0;
        o_result      = '0;

        if (i_info.is_end) begin
            o_emit              = 1'b1;
            o_result.done_res   = 1'b1;
            o_result.byte_count = count_wide[15:0];
            o_result.status     = r_error;
            if (r_error == ST_OK) begin
                if (r_pad == PAD_ONE) begin
                    o_result.status = ST_PAD_MISSING;
                end else if (r_pad == PAD_NONE && r_phase != 2'd0) begin
                    o_result.status = ST_TRUNCATED;
                end
            end
            n_phase       = '0;
            n_partial     = '0;
            n_pad         = PAD_NONE;
            n_count       = '0;
            n_group_bytes = '0;
            n_error       = ST_OK;
        end else if (r_error != ST_OK || r_pad == PAD_DONE || i_info.is_space) begin
            // Ignored: sticky error, trailing text after padding, or whitespace.
        end else if (r_pad == PAD_ONE) begin
            if (i_info.is_pad) begin
                n_pad = PAD_DONE;
                if (r_partial != 8'h00) begin
                    n_error = ST_LEFTOVER;
                end
            end else begin
                n_error = ST_PAD_MISSING;
            end
        end else if (i_info.is_pad) begin
            if (r_phase < 2'd2) begin
                n_error = ST_BAD_PAD;
            end else if (r_phase == 2'd2) begin
                n_pad = PAD_ONE;
            end else begin
                n_pad = PAD_DONE;
                if (r_partial != 8'h00) begin
                    n_error = ST_LEFTOVER;
                end
            end
        end else if (!i_info.is_alpha) begin
            n_error = ST_INVALID;
        end else begin
            case (r_phase)
                2'd0: begin
                    n_group_bytes = group_sum;
                    if (group_sum >= GROUP_BITS'(r_capacity)) begin
                        n_error = ST_OVERFLOW;
                    end else begin
                        n_partial = {v, 2'b00};
                        n_phase   = 2'd1;
                    end
                end
                2'd1: begin
                    o_emit            = 1'b1;
                    o_result.out_byte = r_partial | {6'd0, v[5:4]};
                    n_partial         = {v[3:0], 4'h0};
                    n_phase           = 2'd2;
                end
                2'd2: begin
                    o_emit            = 1'b1;
                    o_result.out_byte = r_partial | {4'd0, v[5:2]};
                    n_partial         = {v[1:0], 6'd0};
                    n_phase           = 2'd3;
                end
                default: begin
                    o_emit            = 1'b1;
                    o_result.out_byte = r_partial | {2'd0, v};
                    n_partial         = 8'h00;
                    n_phase           = 2'd0;
                end
            endcase
            if (o_emit) begin
                o_result.byte_valid = 1'b1;
                n_count             = r_count + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity    <= '1;
            r_phase       <= '0;
            r_partial     <= '0;
            r_pad         <= PAD_NONE;
            r_count       <= '0;
            r_group_bytes <= '0;
            r_error       <= ST_OK;
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (i_fire) begin
                r_phase       <= n_phase;
                r_partial     <= n_partial;
                r_pad         <= n_pad;
                r_count       <= n_count;
                r_group_bytes <= n_group_bytes;
                r_error       <= n_error;
            end
        end
    end

endmodule

`default_nettype wire

[sv/base64_text_decoder.sv]
// Top level of the base64 text decoder: input register, decode core and
// result register. Depends on b64d_pkg, b64d_char_class and b64d_core.
//
// Usage:
//   Input channel: one character per transaction on i_ch (i_valid/o_stall).
//   A zero character ends the string. Output channel (o_valid/i_stall):
//   one result per decoded byte (o_byte_valid) and one end result per
//   string (o_done_res) carrying o_status and o_byte_count. Whitespace,
//   padding and ignored characters produce no result.
//   Configuration: i_cfg_wr_en writes i_cfg_wr_data into the capacity
//   register; write it only while no string is in flight.
//   Throughput: one character per cycle unless the receiver stalls. A
//   character is held in the input register, and its result then in the
//   result register. When the receiver stalls, the result register holds
//   and the input register keeps one character; o_stall then rises,
//   because every character waits for the result register to be free.
//   Reset (i_rst_n low, synchronous): clears all pipeline and string state
//   and sets the capacity to 65535.
`default_nettype none

module base64_text_decoder #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_ch,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic             o_done_res,
    output logic [2:0]       o_status,
    output logic [15:0]      o_byte_count
);
    import b64d_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_out_valid;
    t_result    r_out;
    logic       out_ready;
    logic       fire;
    logic       emit;
    t_char_info info;
    t_result    result;

    // The core step advances whenever the result register can take its output.
    assign out_ready = !r_out_valid || !i_stall;
    assign fire      = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !out_ready;

    b64d_char_class u_class (
        .i_ch   (r_in_ch),
        .o_info (info)
    );

    b64d_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (fire),
        .i_info        (info),
        .o_emit        (emit),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= fire && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_ch <= i_ch;
        end
        if (fire && emit) begin
            r_out <= result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out.out_byte;
    assign o_byte_valid = r_out.byte_valid;
    assign o_done_res   = r_out.done_res;
    assign o_status     = r_out.status;
    assign o_byte_count = r_out.byte_count;

endmodule

`default_nettype wire

[sv/b64d_checker.sv]
// Port-level checker for the base64 text decoder, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module b64d_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [7:0]  o_out_byte,
    input wire logic        o_byte_valid,
    input wire logic        o_done_res,
    input wire logic [2:0]  o_status,
    input wire logic [15:0] o_byte_count
);

    // Every result is either a byte or an end report, never both.
    a_kind_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_byte_valid ^ o_done_res))
        else $error("result is not exactly one of byte or end report");

    // Byte results carry no status or count.
    a_byte_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_valid) |-> (o_status == 3'd0 && o_byte_count == 16'd0))
        else $error("byte result carries status or count");

    // End reports use only defined status codes and carry no byte.
    a_done_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> (o_status != 3'd7 && o_out_byte == 8'd0))
        else $error("end report has bad status or nonzero byte");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_byte)
            && $stable(o_status) && $stable(o_byte_count)))
        else $error("stalled result changed");

endmodule

bind base64_text_decoder b64d_checker u_b64d_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_byte   (o_out_byte),
    .o_byte_valid (o_byte_valid),
    .o_done_res   (o_done_res),
    .o_status     (o_status),
    .o_byte_count (o_byte_count)
);

`default_nettype wire

[sim/base64_text_decoder_checker.sv]
// Checker for the base64 text decoder: watches both channels and the capacity write port,
// predicts every result from the accepted characters and compares them in order.
// Depends on b64d_pkg for the status codes, the padding states and the result layout.
`default_nettype none

module base64_text_decoder_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [7:0]  i_out_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_done_res,
    input  wire logic [2:0]  i_status,
    input  wire logic [15:0] i_byte_count,
    output int               o_pending,
    output int               o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    t_result    decoded_fifo[$];
    logic [15:0] capacity;
    logic [1:0]  group_pos;
    logic [7:0]  carry_bits;
    t_pad_stage  pad_state;
    logic [15:0] bytes_out;
    logic [17:0] reserved_bytes;
    logic [2:0]  first_error;

    task report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_mismatches++;
    endtask

    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return 7'(c - 8'h41);
        if (c >= "a" && c <= "z") return 7'(c - 8'h61 + 8'd26);
        if (c >= "0" && c <= "9") return 7'(c - 8'h30 + 8'd52);
        if (c == "+") return 7'd62;
        if (c == "/") return 7'd63;
        return 7'd64;
    endfunction

    task clear_string();
        group_pos = '0;
        carry_bits = '0;
        pad_state = PAD_NONE;
        bytes_out = '0;
        reserved_bytes = '0;
        first_error = ST_OK;
    endtask

    task close_padding();
        pad_state = PAD_DONE;
        if (carry_bits != 8'h00)
            first_error = ST_LEFTOVER;
    endtask

    task decode_char(input logic [7:0] c);
        t_result    r;
        logic [6:0] v;
        logic [7:0] b;
        r = '0;
        if (c == 8'h00) begin
            r.done_res = 1'b1;
            r.status = first_error;
            if (first_error == ST_OK) begin
                if (pad_state == PAD_ONE)
                    r.status = ST_PAD_MISSING;
                else if (pad_state == PAD_NONE && group_pos != 2'd0)
                    r.status = ST_TRUNCATED;
            end
            r.byte_count = bytes_out;
            decoded_fifo.push_back(r);
            clear_string();
            return;
        end
        if (first_error != ST_OK || pad_state == PAD_DONE)
            return;
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
            return;
        if (pad_state == PAD_ONE) begin
            if (c == PAD_CHAR)
                close_padding();
            else
                first_error = ST_PAD_MISSING;
            return;
        end
        if (c == PAD_CHAR) begin
            if (group_pos < 2'd2)
                first_error = ST_BAD_PAD;
            else if (group_pos == 2'd2)
                pad_state = PAD_ONE;
            else
                close_padding();
            return;
        end
        v = char_to_sextet(c);
        if (v[6]) begin
            first_error = ST_INVALID;
            return;
        end
        case (group_pos)
            2'd0: begin
                // The room check is made once per group, at its first character.
                reserved_bytes = reserved_bytes + 18'd3;
                if (reserved_bytes >= {2'b00, capacity}) begin
                    first_error = ST_OVERFLOW;
                end else begin
                    carry_bits = {v[5:0], 2'b00};
                    group_pos = 2'd1;
                end
                return;
            end
            2'd1: begin
                b = carry_bits | {6'b0, v[5:4]};
                carry_bits = {v[3:0], 4'b0};
                group_pos = 2'd2;
            end
            2'd2: begin
                b = carry_bits | {4'b0, v[5:2]};
                carry_bits = {v[1:0], 6'b0};
                group_pos = 2'd3;
            end
            default: begin
                b = carry_bits | {2'b0, v[5:0]};
                carry_bits = '0;
                group_pos = 2'd0;
            end
        endcase
        bytes_out = bytes_out + 16'd1;
        r.out_byte = b;
        r.byte_valid = 1'b1;
        decoded_fifo.push_back(r);
    endtask

    task check_result();
        t_result got;
        t_result want;
        got = {i_out_byte, i_byte_valid, i_done_res, i_status, i_byte_count};
        if (decoded_fifo.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte=%h bv=%b done=%b st=%0d cnt=%0d",
                got.out_byte, got.byte_valid, got.done_res, got.status, got.byte_count));
            return;
        end
        want = decoded_fifo.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
            got.done_res !== want.done_res || got.status !== want.status ||
            got.byte_count !== want.byte_count)
            report_mismatch($sformatf(
                "got byte=%h bv=%b done=%b st=%0d cnt=%0d, want byte=%h bv=%b done=%b st=%0d cnt=%0d",
                got.out_byte, got.byte_valid, got.done_res, got.status, got.byte_count,
                want.out_byte, want.byte_valid, want.done_res, want.status, want.byte_count));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity = 16'hFFFF;
            clear_string();
            decoded_fifo.delete();
        end else begin
            // Results are checked before this edge's character is predicted, since a
            // result never leaves in the cycle its character is taken.
            if ($isunknown(i_out_valid))
                report_mismatch("o_valid is unknown");
            else if (i_out_valid && !i_out_stall)
                check_result();
            if (i_cfg_wr_en)
                capacity = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall)
                decode_char(i_ch);
        end
        o_pending = decoded_fifo.size();
    end

endmodule

`default_nettype wire

[sim/base64_text_decoder_tb.sv]
// Top of the base64 text decoder testbench: clock, reset, character stimulus, receiver stalls
// and the verdict. Depends on base64_text_decoder, base64_text_decoder_checker and b64d_pkg.
`default_nettype none

module base64_text_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    localparam logic [7:0] END_OF_TEXT = 8'h00;
    localparam int unsigned ITEMS_PER_PHASE = 260;
    localparam int unsigned HOLD_CYCLES = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_ch;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_done_res;
    logic [2:0]  o_status;
    logic [15:0] o_byte_count;

    int          pending;
    int          mismatches;
    bit          idle_on;
    bit          hold_req;
    int unsigned chars_sent;
    logic [7:0]  text_q[$];

    base64_text_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ch          (i_ch),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_done_res    (o_done_res),
        .o_status      (o_status),
        .o_byte_count  (o_byte_count)
    );

    base64_text_decoder_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_ch          (i_ch),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_byte    (o_out_byte),
        .i_byte_valid  (o_byte_valid),
        .i_done_res    (o_done_res),
        .i_status      (o_status),
        .i_byte_count  (o_byte_count),
        .o_pending     (pending),
        .o_mismatches  (mismatches)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("** base64_text_decoder: FAILED **");
        $finish;
    end

    // Receiver side: short random stalls, plus one long hold-off on request.
    initial begin
        int unsigned held;
        bit          hold_done;
        i_stall <= 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge i_clk);
                i_stall <= 1'b0;
                hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        if (v < 6'd26) return 8'h41 + 8'(v);
        if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
        if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
        return (v == 6'd62) ? 8'h2B : 8'h2F;
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task send_char(input logic [7:0] c);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch <= c;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
    endtask

    task send_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task write_capacity(input logic [15:0] value);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        // Whitespace and padding leave no result, so let the pipeline drain.
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed strings with random content and spacing; the rest are broken
    // strings and plain noise.
    task automatic build_random_text();
        int          kind;
        int          nbytes;
        int          rem;
        int          i;
        int          pos;
        int          ws;
        logic [23:0] w;
        logic [7:0]  raw[$];
        logic [7:0]  enc[$];
        text_q = {};
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(1, 255)));
        end else begin
            nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            for (i = 0; i < nbytes; i++)
                raw.push_back(8'($urandom_range(0, 255)));
            for (i = 0; i < nbytes; i += 3) begin
                rem = nbytes - i;
                w = {raw[i], 16'h0000};
                if (rem > 1) w[15:8] = raw[i + 1];
                if (rem > 2) w[7:0] = raw[i + 2];
                enc.push_back(sextet_to_char(w[23:18]));
                enc.push_back(sextet_to_char(w[17:12]));
                enc.push_back((rem > 1) ? sextet_to_char(w[11:6]) : PAD_CHAR);
                enc.push_back((rem > 2) ? sextet_to_char(w[5:0]) : PAD_CHAR);
            end
            if (kind == 6 && nbytes % 3 != 0) begin
                // Dirty the bits that the padding throws away.
                pos = enc.size() - ((nbytes % 3 == 1) ? 2 : 1) - 1;
                enc[pos] = sextet_to_char(6'($urandom_range(0, 63)));
            end else if (kind >= 7) begin
                if (enc.size() == 0) begin
                    enc.push_back(8'($urandom_range(1, 255)));
                end else begin
                    pos = $urandom_range(0, enc.size() - 1);
                    case ($urandom_range(0, 3))
                        0: enc[pos] = 8'($urandom_range(1, 255));
                        1: enc.delete(pos);
                        2: enc.insert(pos, PAD_CHAR);
                        default: enc = enc[0:pos];
                    endcase
                end
            end
            for (i = 0; i < enc.size(); i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    ws = $urandom_range(8, 13);
                    text_q.push_back((ws == 8) ? 8'h20 : 8'(ws));
                end
                text_q.push_back(enc[i]);
            end
            if (kind <= 5 && nbytes % 3 != 0 && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(1, 255)));
        end
        text_q.push_back(END_OF_TEXT);
    endtask

    initial begin
        int        phase;
        int        i;
        logic [15:0] cap_value;
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= '0;
        i_valid <= 1'b0;
        i_ch <= '0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        chars_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Alphabet extremes with whitespace between groups.
        send_str("Az+/");
        send_char(8'h09);
        send_str("09az");
        send_char(8'h0A);
        send_char(END_OF_TEXT);
        // Two pads split by whitespace, then a character that must be ignored.
        send_str("QQ=");
        send_char(8'h0B);
        send_char(8'h0C);
        send_str("=");
        send_char(8'h0D);
        send_str("x");
        send_char(END_OF_TEXT);
        // Pad at the start of a group.
        send_str("=");
        send_char(END_OF_TEXT);
        // Second pad missing.
        send_str("QR=A");
        send_char(END_OF_TEXT);
        // Truncated group.
        send_str("QUJ");
        send_char(END_OF_TEXT);
        // Character outside the alphabet.
        send_char(8'hFF);
        send_char(END_OF_TEXT);
        // Nonzero bits under the padding.
        send_str("QR==");
        send_char(END_OF_TEXT);

        hold_req = 1'b1;
        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                1: cap_value = 16'd0;
                2: cap_value = 16'd3;
                3: cap_value = 16'($urandom_range(4, 48));
                4: cap_value = 16'hFFFF;
                5: cap_value = 16'($urandom_range(0, 65535));
                default: cap_value = 16'($urandom_range(6, 30));
            endcase
            if (phase > 0)
                write_capacity(cap_value);
            if (phase == 6)
                idle_on = 1'b0;
            while (chars_sent < (phase + 1) * ITEMS_PER_PHASE) begin
                build_random_text();
                for (i = 0; i < text_q.size(); i++)
                    send_char(text_q[i]);
            end
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (6) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("** base64_text_decoder: PASSED **");
        else
            $display("** base64_text_decoder: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
